/* hw/rtl/pehs_pkg.sv */
// ----------------------------------------------------------------------------
// pehs_pkg
// shared types, constants and the entry ordering for the event scheduler
// ----------------------------------------------------------------------------
package pehs_pkg;

    localparam int MaxSources = 1024;
    localparam int TimeBits   = 48;
    localparam int CountW     = $clog2(MaxSources + 1);
    localparam int KindW      = 2;
    localparam int IdW        = 32;
    localparam int PeriodW    = 16;
    localparam int EventTimeW = 48;

    localparam logic [KindW-1:0]    KindLoad  = 2'd0;
    localparam logic [KindW-1:0]    KindClear = 2'd1;
    localparam logic [KindW-1:0]    KindPop   = 2'd2;
    localparam logic [TimeBits-1:0] TimeMax   = '1;
    localparam logic [CountW-1:0]   CountMax  = CountW'(MaxSources);

    typedef struct packed {
        logic [TimeBits-1:0] due;
        logic [IdW-1:0]      id;
        logic [PeriodW-1:0]  period;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_INS,
        ST_ERR
    } state_t;

    // due time first, then id, then period
    function automatic logic entry_before(entry_t a, entry_t b);
        return (a < b);
    endfunction

endpackage

/* hw/rtl/pehs_cell.sv */
// ----------------------------------------------------------------------------
// pehs_cell
// one slot of the sorted source list: holds an entry, takes an inserted
// entry or its left neighbour's on insert, its right neighbour's on a pop
// ----------------------------------------------------------------------------
module pehs_cell (
    input  logic              clk,
    input  pehs_pkg::cell_op_t op,
    input  logic              occupied,
    input  pehs_pkg::entry_t  ins_entry,
    input  pehs_pkg::entry_t  left_entry,
    input  logic              left_ahead,
    input  pehs_pkg::entry_t  right_entry,
    output pehs_pkg::entry_t  entry,
    output logic              ins_ahead
);

    pehs_pkg::entry_t entry_reg;
    pehs_pkg::entry_t entry_next;

    always_comb
    begin
        ins_ahead = !occupied || pehs_pkg::entry_before(ins_entry, entry_reg);
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (op.shift)
        begin
            entry_next = right_entry;
        end
        else if (op.insert && ins_ahead)
        begin
            entry_next = left_ahead ? left_entry : ins_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* hw/rtl/periodic_event_heap_scheduler_core.sv */
// ----------------------------------------------------------------------------
// periodic_event_heap_scheduler_core
// periodic source scheduler kept as a sorted row of cells, earliest at the head
// ----------------------------------------------------------------------------
// input channel: item_valid / item_stall with kind, source_id, period
//   load adds a source due at its period, clear empties the list,
//   pop emits the earliest source and puts it back one period later
// output channel: event_valid / event_stall with event_id, event_time,
//   error, time_saturated; one beat per pop and per failed load
// every cell compares the inserted entry with its own in parallel, so an
//   insert or a removal moves all cells at once, whatever the fill level
// clear acts in idle, load passes the insert state, pop the pop state
//   (result register) then insert (reinsertion); the pop state sets the beat
// a pending result does not block loads or clears; a pop or a failed load
//   waits while the previous beat is stalled, holding item_stall high
// reset empties the list at once (the fill count goes to zero) and drops
//   any beat that was waiting; no clearing pass is needed
// ----------------------------------------------------------------------------
module periodic_event_heap_scheduler_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [pehs_pkg::KindW-1:0]          kind,
    input  logic [pehs_pkg::IdW-1:0]            source_id,
    input  logic [pehs_pkg::PeriodW-1:0]        period,
    output logic                                event_valid,
    input  logic                                event_stall,
    output logic [pehs_pkg::IdW-1:0]            event_id,
    output logic [pehs_pkg::EventTimeW-1:0]     event_time,
    output logic                                error,
    output logic                                time_saturated
);

    pehs_pkg::state_t state_reg;
    pehs_pkg::state_t state_next;

    logic [pehs_pkg::CountW-1:0] count_reg;
    logic [pehs_pkg::CountW-1:0] count_next;
    pehs_pkg::entry_t            pend_reg;
    pehs_pkg::entry_t            pend_next;

    logic                              event_valid_reg;
    logic                              event_valid_next;
    logic [pehs_pkg::IdW-1:0]          event_id_reg;
    logic [pehs_pkg::IdW-1:0]          event_id_next;
    logic [pehs_pkg::EventTimeW-1:0]   event_time_reg;
    logic [pehs_pkg::EventTimeW-1:0]   event_time_next;
    logic                              error_reg;
    logic                              error_next;
    logic                              sat_reg;
    logic                              sat_next;

    logic                     accept;
    logic                     slot_free;
    logic                     pop_emit;
    logic                     err_emit;
    logic                     load_go;
    logic                     clear_go;
    pehs_pkg::cell_op_t       cell_op;

    pehs_pkg::entry_t                 head;
    logic [pehs_pkg::TimeBits:0]      due_sum;
    logic                             due_sat;
    logic [pehs_pkg::TimeBits-1:0]    due_adv;

    pehs_pkg::entry_t entries [pehs_pkg::MaxSources];
    logic             befores [pehs_pkg::MaxSources];

    assign slot_free = !event_valid_reg || !event_stall;
    assign accept    = item_valid && !item_stall;
    assign head      = entries[0];

    assign due_sum = {1'b0, head.due} + (pehs_pkg::TimeBits + 1)'(head.period);
    assign due_sat = due_sum[pehs_pkg::TimeBits];
    assign due_adv = due_sat ? pehs_pkg::TimeMax : due_sum[pehs_pkg::TimeBits-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pehs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        pehs_pkg::KindLoad:
                        begin
                            state_next = (count_reg == pehs_pkg::CountMax) ?
                                         pehs_pkg::ST_ERR : pehs_pkg::ST_INS;
                        end
                        pehs_pkg::KindPop:
                        begin
                            state_next = (count_reg == '0) ?
                                         pehs_pkg::ST_ERR : pehs_pkg::ST_POP;
                        end
                        default:
                        begin
                            state_next = pehs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pehs_pkg::ST_POP:
            begin
                if (slot_free)
                begin
                    state_next = pehs_pkg::ST_INS;
                end
            end
            pehs_pkg::ST_INS:
            begin
                state_next = pehs_pkg::ST_IDLE;
            end
            pehs_pkg::ST_ERR:
            begin
                if (slot_free)
                begin
                    state_next = pehs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pehs_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        item_stall     = 1'b1;
        pop_emit       = 1'b0;
        err_emit       = 1'b0;
        load_go        = 1'b0;
        clear_go       = 1'b0;
        cell_op.insert = 1'b0;
        cell_op.shift  = 1'b0;
        case (state_reg)
            pehs_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                load_go    = item_valid && (kind == pehs_pkg::KindLoad) &&
                             (count_reg != pehs_pkg::CountMax);
                clear_go   = item_valid && (kind == pehs_pkg::KindClear);
            end
            pehs_pkg::ST_POP:
            begin
                pop_emit      = slot_free;
                cell_op.shift = slot_free;
            end
            pehs_pkg::ST_INS:
            begin
                cell_op.insert = 1'b1;
            end
            pehs_pkg::ST_ERR:
            begin
                err_emit = slot_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next       = count_reg;
        pend_next        = pend_reg;
        event_valid_next = event_valid_reg && event_stall;
        event_id_next    = event_id_reg;
        event_time_next  = event_time_reg;
        error_next       = error_reg;
        sat_next         = sat_reg;

        if (clear_go)
        begin
            count_next = '0;
        end
        if (load_go)
        begin
            pend_next.due    = pehs_pkg::TimeBits'(period);
            pend_next.id     = source_id;
            pend_next.period = period;
        end
        if (pop_emit)
        begin
            count_next       = count_reg - 1'b1;
            pend_next.due    = due_adv;
            pend_next.id     = head.id;
            pend_next.period = head.period;
            event_valid_next = 1'b1;
            event_id_next    = head.id;
            event_time_next  = pehs_pkg::EventTimeW'(head.due);
            error_next       = 1'b0;
            sat_next         = due_sat;
        end
        if (err_emit)
        begin
            event_valid_next = 1'b1;
            event_id_next    = '0;
            event_time_next  = '0;
            error_next       = 1'b1;
            sat_next         = 1'b0;
        end
        if (cell_op.insert)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pehs_pkg::ST_IDLE;
            count_reg       <= '0;
            event_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            event_valid_reg <= event_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg       <= pend_next;
        event_id_reg   <= event_id_next;
        event_time_reg <= event_time_next;
        error_reg      <= error_next;
        sat_reg        <= sat_next;
    end

    // row of cells, head at index 0
    for (genvar i = 0; i < pehs_pkg::MaxSources; i++)
    begin : g_cell
        logic             occupied;
        pehs_pkg::entry_t left_entry;
        logic             left_before;
        pehs_pkg::entry_t right_entry;

        assign occupied = (pehs_pkg::CountW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_entry  = pend_reg;
            assign left_before = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry  = entries[i-1];
            assign left_before = befores[i-1];
        end

        if (i == pehs_pkg::MaxSources - 1)
        begin : g_last
            assign right_entry = entries[i];
        end
        else
        begin : g_body
            assign right_entry = entries[i+1];
        end

        pehs_cell u_cell (
            .clk         (clk),
            .op          (cell_op),
            .occupied    (occupied),
            .ins_entry   (pend_reg),
            .left_entry  (left_entry),
            .left_ahead  (left_before),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .ins_ahead   (befores[i])
        );
    end

    assign event_valid    = event_valid_reg;
    assign event_id       = event_id_reg;
    assign event_time     = event_time_reg;
    assign error          = error_reg;
    assign time_saturated = sat_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pehs_pkg::CountMax)
        else $error("fill count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pehs_pkg::ST_INS) |-> (count_reg < pehs_pkg::CountMax))
        else $error("insert into a full row");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pehs_pkg::ST_POP) |-> (count_reg != '0))
        else $error("pop with no entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop_emit |=> (state_reg == pehs_pkg::ST_INS) && event_valid_reg && !error_reg)
        else $error("pop beat not followed by reinsertion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid_reg && error_reg) |->
            (event_id_reg == '0) && (event_time_reg == '0) && !sat_reg)
        else $error("error beat carries data");
`endif

endmodule
